// ----- src/jpeg_sof_info_extractor_macros.svh -----
// Assertion macros for the JPEG frame header extractor.
`ifndef JPEG_SOF_INFO_EXTRACTOR_MACROS_SVH
`define JPEG_SOF_INFO_EXTRACTOR_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define JSOF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsof check failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define JSOF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsof check failed");

`endif

// ----- src/jsof_pkg.sv -----
// Shared types, constants and tables for the JPEG frame header extractor.
package jsof_pkg;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF2   = 8'hC2;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_TEM    = 8'h01;

  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] LEN_SOF_MIN = 16'd7;

  localparam logic [31:0] RED_HI_TEST = 32'hD0D0D0D0;
  localparam logic [31:0] RED_LO_TEST = 32'h0D0D0D0D;
  localparam logic [31:0] RED_HI_MASK = 32'hF0F0F0F0;
  localparam logic [31:0] RED_LO_MASK = 32'h0F0F0F0F;

  localparam logic [7:0] ID_R = 8'h52;
  localparam logic [7:0] ID_G = 8'h47;
  localparam logic [7:0] ID_B = 8'h42;

  localparam logic [7:0] PREC_LOW_MAX = 8'd8;
  localparam logic [7:0] QUANT_LIMIT  = 8'd4;
  localparam logic [4:0] IDX_PREC     = 5'd0;
  localparam logic [4:0] IDX_HGT_HI   = 5'd1;
  localparam logic [4:0] IDX_HGT_LO   = 5'd2;
  localparam logic [4:0] IDX_WID_HI   = 5'd3;
  localparam logic [4:0] IDX_WID_LO   = 5'd4;
  localparam logic [4:0] IDX_NCOMP    = 5'd5;
  localparam logic [4:0] IDX_COMP0    = 5'd6;
  localparam logic [7:0] NCOMP_MAX    = 8'd4;
  localparam logic [7:0] NCOMP_GRAY   = 8'd1;
  localparam logic [7:0] NCOMP_COLOUR = 8'd3;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_CODE = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_HDR  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;
  localparam logic [2:0] PH_FAIL = 3'd7;

  localparam logic [1:0] CB_ID     = 2'd0;
  localparam logic [1:0] CB_FACTOR = 2'd1;
  localparam logic [1:0] CB_QUANT  = 2'd2;

  localparam logic [3:0] FMT_NONE      = 4'd0;
  localparam logic [3:0] FMT_GRAY8     = 4'd1;
  localparam logic [3:0] FMT_GRAY16    = 4'd2;
  localparam logic [3:0] FMT_GBRP      = 4'd3;
  localparam logic [3:0] FMT_GBRP16    = 4'd4;
  localparam logic [3:0] FMT_YUV444P   = 4'd5;
  localparam logic [3:0] FMT_YUV440P   = 4'd6;
  localparam logic [3:0] FMT_YUV422P   = 4'd7;
  localparam logic [3:0] FMT_YUV422P16 = 4'd8;
  localparam logic [3:0] FMT_YUV420P   = 4'd9;
  localparam logic [3:0] FMT_YUV420P16 = 4'd10;
  localparam logic [3:0] FMT_YUV411P   = 4'd11;

  typedef struct packed {
    logic [7:0]      precision;
    logic [7:0]      comp_total;
    logic [2:0][7:0] factors;
    logic [2:0][7:0] ids;
    logic            invalid;
  } fmt_in_t;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic [7:0]  precision;
    logic [15:0] height;
    logic [15:0] width;
    logic [3:0]  pix_fmt;
  } res_t;

  typedef struct packed {
    logic [1:0] comp;
    logic [1:0] slot;
  } comp_pos_t;

  // Component number and byte slot for a header byte index past the count byte.
  function automatic comp_pos_t comp_pos(input logic [4:0] idx);
    comp_pos_t p;
    p = '{comp: 2'd3, slot: CB_ID};
    case (idx)
      5'd6:  p = '{comp: 2'd0, slot: CB_ID};
      5'd7:  p = '{comp: 2'd0, slot: CB_FACTOR};
      5'd8:  p = '{comp: 2'd0, slot: CB_QUANT};
      5'd9:  p = '{comp: 2'd1, slot: CB_ID};
      5'd10: p = '{comp: 2'd1, slot: CB_FACTOR};
      5'd11: p = '{comp: 2'd1, slot: CB_QUANT};
      5'd12: p = '{comp: 2'd2, slot: CB_ID};
      5'd13: p = '{comp: 2'd2, slot: CB_FACTOR};
      5'd14: p = '{comp: 2'd2, slot: CB_QUANT};
      5'd15: p = '{comp: 2'd3, slot: CB_ID};
      5'd16: p = '{comp: 2'd3, slot: CB_FACTOR};
      5'd17: p = '{comp: 2'd3, slot: CB_QUANT};
      default: p = '{comp: 2'd3, slot: CB_ID};
    endcase
    return p;
  endfunction

  function automatic logic [3:0] gbr_lookup(input logic [23:0] m, input logic low);
    logic [3:0] f;
    f = FMT_NONE;
    if (m == 24'h111111) begin
      f = low ? FMT_GBRP : FMT_GBRP16;
    end else if (m inside {24'h121111, 24'h141212, 24'h141111, 24'h222111, 24'h221121,
                           24'h211111}) begin
      f = low ? FMT_GBRP : FMT_NONE;
    end
    return f;
  endfunction

  function automatic logic [3:0] yuv_lookup(input logic [23:0] m, input logic low);
    logic [3:0] f;
    f = FMT_NONE;
    if (m inside {24'h111111, 24'h121211, 24'h221221, 24'h212111, 24'h222112, 24'h222211,
                  24'h221122, 24'h112222, 24'h311111}) begin
      f = low ? FMT_YUV444P : FMT_NONE;
    end else if (m inside {24'h121111, 24'h141212, 24'h141111, 24'h222111, 24'h221121}) begin
      f = low ? FMT_YUV440P : FMT_NONE;
    end else if (m == 24'h211111) begin
      f = low ? FMT_YUV422P : FMT_YUV422P16;
    end else if (m inside {24'h221211, 24'h221112}) begin
      f = low ? FMT_YUV422P : FMT_NONE;
    end else if (m == 24'h221111) begin
      f = low ? FMT_YUV420P : FMT_YUV420P16;
    end else if (m inside {24'h421111, 24'h241111}) begin
      f = low ? FMT_YUV420P : FMT_NONE;
    end else if (m == 24'h411111) begin
      f = low ? FMT_YUV411P : FMT_NONE;
    end
    return f;
  endfunction

endpackage

// ----- src/jsof_fmt.sv -----
// Pixel format decode from the gathered frame header fields.
module jsof_fmt (
  input  jsof_pkg::fmt_in_t   hdr,
  output logic [3:0]          pix_fmt
);
  import jsof_pkg::*;

  logic        low;
  logic        rgb;
  logic [31:0] mask_raw;
  logic [31:0] mask_a;
  logic [31:0] mask_b;

  assign low      = (hdr.precision <= PREC_LOW_MAX);
  assign rgb      = (hdr.ids[0] == ID_R) && (hdr.ids[1] == ID_G) && (hdr.ids[2] == ID_B);
  assign mask_raw = {hdr.factors[0], hdr.factors[1], hdr.factors[2], 8'h00};

  always_comb begin
    mask_a = mask_raw;
    if ((mask_raw & RED_HI_TEST) == 32'h0) begin
      mask_a = mask_raw - ((mask_raw & RED_HI_MASK) >> 1);
    end
    mask_b = mask_a;
    if ((mask_a & RED_LO_TEST) == 32'h0) begin
      mask_b = mask_a - ((mask_a & RED_LO_MASK) >> 1);
    end
  end

  always_comb begin
    if (hdr.invalid) begin
      pix_fmt = FMT_NONE;
    end else if (hdr.comp_total == NCOMP_GRAY) begin
      pix_fmt = low ? FMT_GRAY8 : FMT_GRAY16;
    end else if (hdr.comp_total != NCOMP_COLOUR) begin
      pix_fmt = FMT_NONE;
    end else if (rgb) begin
      pix_fmt = gbr_lookup(mask_b[31:8], low);
    end else begin
      pix_fmt = yuv_lookup(mask_b[31:8], low);
    end
  end

endmodule

// ----- src/jsof_parse.sv -----
// Marker scanner and frame header capture, one byte per step.
module jsof_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     data_byte,
  input  logic           stream_end,
  output jsof_pkg::res_t res
);
  import jsof_pkg::*;

  logic [2:0]      phase_r, phase_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [7:0]      lenh_r, lenh_nxt;
  logic [15:0]     skip_r, skip_nxt;
  logic [4:0]      idx_r, idx_nxt;
  logic [7:0]      prec_r, prec_nxt;
  logic [15:0]     hgt_r, hgt_nxt;
  logic [15:0]     wid_r, wid_nxt;
  logic [7:0]      ncomp_r, ncomp_nxt;
  logic [2:0][7:0] fac_r, fac_nxt;
  logic [2:0][7:0] ids_r, ids_nxt;
  logic            inv_r, inv_nxt;

  logic [15:0]     len;
  logic            inv_now;
  comp_pos_t       pos;
  fmt_in_t         fin;
  logic [3:0]      fmt_val;

  assign fin = '{precision: prec_r, comp_total: ncomp_r, factors: fac_r, ids: ids_r,
                 invalid: inv_r};

  jsof_fmt u_fmt (
    .hdr     (fin),
    .pix_fmt (fmt_val)
  );

  assign pos = comp_pos(idx_r);

  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    lenh_nxt  = lenh_r;
    skip_nxt  = skip_r;
    idx_nxt   = idx_r;
    prec_nxt  = prec_r;
    hgt_nxt   = hgt_r;
    wid_nxt   = wid_r;
    ncomp_nxt = ncomp_r;
    fac_nxt   = fac_r;
    ids_nxt   = ids_r;
    inv_nxt   = inv_r;
    res       = '0;
    len       = {lenh_r, data_byte};
    inv_now   = inv_r;
    if (len < LEN_MIN) begin
      len = LEN_MIN;
    end
    case (phase_r)
      PH_WAIT: begin
        if (data_byte == MK_PREFIX) begin
          phase_nxt = PH_CODE;
        end
      end
      PH_CODE: begin
        code_nxt  = data_byte;
        phase_nxt = (data_byte inside {[MK_RST0:MK_EOI], MK_TEM}) ? PH_WAIT : PH_LENH;
      end
      PH_LENH: begin
        lenh_nxt  = data_byte;
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        if (code_r inside {MK_SOF0, MK_SOF2}) begin
          if (len < LEN_SOF_MIN) begin
            phase_nxt = PH_FAIL;
          end else begin
            phase_nxt = PH_HDR;
            idx_nxt   = '0;
            inv_nxt   = 1'b0;
            prec_nxt  = '0;
            hgt_nxt   = '0;
            wid_nxt   = '0;
            ncomp_nxt = '0;
            fac_nxt   = '0;
            ids_nxt   = '0;
          end
        end else begin
          skip_nxt  = len - LEN_MIN;
          phase_nxt = (skip_nxt != 16'd0) ? PH_SKIP : PH_WAIT;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == 16'd0) begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_HDR: begin
        idx_nxt = idx_r + 5'd1;
        if (idx_r == IDX_PREC) begin
          prec_nxt = data_byte;
        end else if (idx_r == IDX_HGT_HI) begin
          hgt_nxt = {data_byte, 8'h00};
        end else if (idx_r == IDX_HGT_LO) begin
          hgt_nxt = {hgt_r[15:8], data_byte};
        end else if (idx_r == IDX_WID_HI) begin
          wid_nxt = {data_byte, 8'h00};
        end else if (idx_r == IDX_WID_LO) begin
          wid_nxt = {wid_r[15:8], data_byte};
        end else if (idx_r == IDX_NCOMP) begin
          ncomp_nxt = data_byte;
          if ((data_byte == 8'd0) || (data_byte > NCOMP_MAX)) begin
            inv_nxt   = 1'b1;
            phase_nxt = PH_DONE;
            res       = '{valid: 1'b1, status: 1'b0, precision: prec_r, height: hgt_r,
                          width: wid_r, pix_fmt: FMT_NONE};
          end
        end else begin
          case (pos.slot)
            CB_ID: begin
              if (pos.comp != 2'd3) begin
                ids_nxt[pos.comp] = data_byte;
              end
            end
            CB_FACTOR: begin
              if (pos.comp != 2'd3) begin
                fac_nxt[pos.comp] = data_byte;
              end
              if ((data_byte[7:4] == 4'd0) || (data_byte[3:0] == 4'd0)) begin
                inv_nxt = 1'b1;
              end
            end
            CB_QUANT: begin
              inv_now = inv_r || (data_byte >= QUANT_LIMIT);
              inv_nxt = inv_now;
              if (inv_now || ({5'd0, {1'b0, pos.comp} + 3'd1} >= ncomp_r)) begin
                phase_nxt = PH_DONE;
                res       = '{valid: 1'b1, status: 1'b0, precision: prec_r, height: hgt_r,
                              width: wid_r, pix_fmt: inv_now ? FMT_NONE : fmt_val};
              end
            end
            default: begin
            end
          endcase
        end
      end
      PH_DONE, PH_FAIL: begin
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    if (stream_end) begin
      if (!res.valid) begin
        if ((phase_nxt == PH_HDR) && (idx_nxt >= IDX_COMP0)) begin
          res = '{valid: 1'b1, status: 1'b0, precision: prec_r, height: hgt_r,
                  width: wid_r, pix_fmt: FMT_NONE};
        end else if (phase_nxt != PH_DONE) begin
          res = '{valid: 1'b1, status: 1'b1, precision: '0, height: '0,
                  width: '0, pix_fmt: FMT_NONE};
        end
      end
      phase_nxt = PH_WAIT;
      code_nxt  = '0;
      lenh_nxt  = '0;
      skip_nxt  = '0;
      idx_nxt   = '0;
      prec_nxt  = '0;
      hgt_nxt   = '0;
      wid_nxt   = '0;
      ncomp_nxt = '0;
      fac_nxt   = '0;
      ids_nxt   = '0;
      inv_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      code_r  <= '0;
      lenh_r  <= '0;
      skip_r  <= '0;
      idx_r   <= '0;
      prec_r  <= '0;
      hgt_r   <= '0;
      wid_r   <= '0;
      ncomp_r <= '0;
      fac_r   <= '0;
      ids_r   <= '0;
      inv_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      lenh_r  <= lenh_nxt;
      skip_r  <= skip_nxt;
      idx_r   <= idx_nxt;
      prec_r  <= prec_nxt;
      hgt_r   <= hgt_nxt;
      wid_r   <= wid_nxt;
      ncomp_r <= ncomp_nxt;
      fac_r   <= fac_nxt;
      ids_r   <= ids_nxt;
      inv_r   <= inv_nxt;
    end
  end

endmodule

// ----- src/jpeg_sof_info_extractor.sv -----
// Top level of the JPEG frame header extractor: input and result registers around the parser.
// One stream byte is taken per cycle while no result is stalled; a byte is held in the input
// register and its result, if any, is then registered in the result register. The only stall
// is a result waiting in the result register while out_ready is low, which holds the byte in
// the input register. At most one result is given per image: found once the frame header is
// complete or found invalid, or cut short by stream_end after its component count (format
// none then), or not-found when stream_end arrives without one.
`include "jpeg_sof_info_extractor_macros.svh"

module jpeg_sof_info_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_status,
  output logic [7:0]  out_precision,
  output logic [15:0] out_image_height,
  output logic [15:0] out_image_width,
  output logic [3:0]  out_pixel_format
);
  import jsof_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       step;
  res_t       res;
  logic       out_valid_r;
  res_t       out_r;

  assign step     = in_valid_r && !(out_valid_r && !out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      end_r  <= in_stream_end;
    end
  end

  jsof_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (byte_r),
    .stream_end (end_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_status = out_r.status;
  assign out_precision     = out_r.precision;
  assign out_image_height  = out_r.height;
  assign out_image_width   = out_r.width;
  assign out_pixel_format  = out_r.pix_fmt;

  `JSOF_ASSERT(a_notfound_zero, out_valid && out_result_status,
               (out_precision == 8'd0) && (out_image_height == 16'd0) &&
               (out_image_width == 16'd0) && (out_pixel_format == FMT_NONE))
  `JSOF_ASSERT(a_fmt_range, out_valid, out_pixel_format <= FMT_YUV411P)
  `JSOF_ASSERT_NEXT(a_hold_byte, in_valid_r && !step, in_valid_r)

endmodule
